[rtl/allm_pkg.sv]
// Shared types and codes for the array linked list manager.
package allm_pkg;

    localparam int REQ_W    = 2;
    localparam int SLOT_W   = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SLOT_W-1:0] slot_index;
        logic [WORD_W-1:0] data_word;
    } allm_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [WORD_W-1:0]   data_out;
        logic                has_prev;
        logic [SLOT_W-1:0]   prev_slot;
        logic                has_next;
        logic [SLOT_W-1:0]   next_slot;
        logic                list_empty;
        logic [SLOT_W-1:0]   head_slot;
        logic [SLOT_W-1:0]   tail_slot;
        logic [COUNT_W-1:0]  count;
    } allm_resp_t;

    // Free list commands from the list controller.
    typedef struct packed {
        logic pop;
        logic push;
    } allm_free_cmd_t;

    // Write enables into the slot store.
    typedef struct packed {
        logic next_we;
        logic prev_we;
        logic data_we;
        logic use_we;
        logic use_val;
    } allm_store_wr_t;

endpackage

[rtl/allm_free_list.sv]
// Free slot list: pushed-slot stack in front of a never-used slot counter.
module allm_free_list
    import allm_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  allm_free_cmd_t                        cmd,
    input  logic [$clog2(CAPACITY)-1:0]           push_slot,
    output logic [$clog2(CAPACITY)-1:0]           top_slot,
    output logic                                  full,
    output logic [$clog2(CAPACITY+1)-1:0]         fresh_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    logic [PTR_W-1:0] link_mem [CAPACITY];

    logic [PTR_W-1:0]  free_ptr_reg, free_ptr_next;
    logic [PTR_W-1:0]  fresh_reg, fresh_next;
    logic [PTR_W-1:0]  free_nx_reg, free_nx_next;
    logic [PTR_W-1:0]  link_rd_reg;
    logic [ADDR_W-1:0] link_raddr;
    logic              top_fresh;

    assign top_fresh   = (free_ptr_reg == fresh_reg);
    assign full        = (free_ptr_reg == NIL);
    assign top_slot    = free_ptr_reg[ADDR_W-1:0];
    assign fresh_count = fresh_reg;

    always_comb begin
        free_ptr_next = free_ptr_reg;
        fresh_next    = fresh_reg;
        free_nx_next  = free_nx_reg;
        if (cmd.pop) begin
            if (top_fresh) begin
                free_ptr_next = fresh_reg + 1'b1;
                fresh_next    = fresh_reg + 1'b1;
            end else begin
                free_ptr_next = free_nx_reg;
                free_nx_next  = link_rd_reg;
            end
        end else if (cmd.push) begin
            free_ptr_next = PTR_W'(push_slot);
            free_nx_next  = free_ptr_reg;
        end
    end

    // Prefetch the link of the second free entry so back-to-back pops work.
    assign link_raddr = (free_nx_next < NIL) ? free_nx_next[ADDR_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_ptr_reg <= '0;
            fresh_reg    <= '0;
            free_nx_reg  <= NIL;
        end else begin
            free_ptr_reg <= free_ptr_next;
            fresh_reg    <= fresh_next;
            free_nx_reg  <= free_nx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            link_mem[push_slot] <= free_ptr_reg;
        end
        link_rd_reg <= link_mem[link_raddr];
    end

endmodule

[rtl/allm_slot_store.sv]
// Slot store: link, data and in-use memories with one-deep write forwarding.
module allm_slot_store
    import allm_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int STORE_W  = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  allm_store_wr_t              wr,
    input  logic [$clog2(CAPACITY)-1:0] next_waddr,
    input  logic [$clog2(CAPACITY)-1:0] next_wdata,
    input  logic [$clog2(CAPACITY)-1:0] prev_waddr,
    input  logic [$clog2(CAPACITY)-1:0] prev_wdata,
    input  logic [$clog2(CAPACITY)-1:0] data_waddr,
    input  logic [STORE_W-1:0]          data_wdata,
    input  logic [$clog2(CAPACITY)-1:0] use_waddr,
    output logic [$clog2(CAPACITY)-1:0] rd_next,
    output logic [$clog2(CAPACITY)-1:0] rd_prev,
    output logic [STORE_W-1:0]          rd_data,
    output logic                        rd_use
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic [ADDR_W-1:0]  next_mem [CAPACITY];
    logic [ADDR_W-1:0]  prev_mem [CAPACITY];
    logic [STORE_W-1:0] data_mem [CAPACITY];
    logic               use_mem  [CAPACITY];

    logic [ADDR_W-1:0]  raddr_reg;
    logic [ADDR_W-1:0]  next_rd_reg, prev_rd_reg;
    logic [STORE_W-1:0] data_rd_reg;
    logic               use_rd_reg;

    // Last write to each memory, to cover a read issued on the same edge.
    logic               next_fv_reg, prev_fv_reg, data_fv_reg, use_fv_reg;
    logic [ADDR_W-1:0]  next_fa_reg, prev_fa_reg, data_fa_reg, use_fa_reg;
    logic [ADDR_W-1:0]  next_fd_reg, prev_fd_reg;
    logic [STORE_W-1:0] data_fd_reg;
    logic               use_fd_reg;

    always_ff @(posedge aclk) begin
        if (wr.next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (wr.prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (wr.data_we) begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (wr.use_we) begin
            use_mem[use_waddr] <= wr.use_val;
        end
        if (rd_en) begin
            raddr_reg   <= rd_addr;
            next_rd_reg <= next_mem[rd_addr];
            prev_rd_reg <= prev_mem[rd_addr];
            data_rd_reg <= data_mem[rd_addr];
            use_rd_reg  <= use_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_fv_reg <= 1'b0;
            prev_fv_reg <= 1'b0;
            data_fv_reg <= 1'b0;
            use_fv_reg  <= 1'b0;
        end else begin
            if (wr.next_we) begin
                next_fv_reg <= 1'b1;
            end
            if (wr.prev_we) begin
                prev_fv_reg <= 1'b1;
            end
            if (wr.data_we) begin
                data_fv_reg <= 1'b1;
            end
            if (wr.use_we) begin
                use_fv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.next_we) begin
            next_fa_reg <= next_waddr;
            next_fd_reg <= next_wdata;
        end
        if (wr.prev_we) begin
            prev_fa_reg <= prev_waddr;
            prev_fd_reg <= prev_wdata;
        end
        if (wr.data_we) begin
            data_fa_reg <= data_waddr;
            data_fd_reg <= data_wdata;
        end
        if (wr.use_we) begin
            use_fa_reg <= use_waddr;
            use_fd_reg <= wr.use_val;
        end
    end

    assign rd_next = (next_fv_reg && next_fa_reg == raddr_reg) ? next_fd_reg : next_rd_reg;
    assign rd_prev = (prev_fv_reg && prev_fa_reg == raddr_reg) ? prev_fd_reg : prev_rd_reg;
    assign rd_data = (data_fv_reg && data_fa_reg == raddr_reg) ? data_fd_reg : data_rd_reg;
    assign rd_use  = (use_fv_reg && use_fa_reg == raddr_reg) ? use_fd_reg : use_rd_reg;

endmodule

[rtl/array_linked_list_manager_core.sv]
// Top level of the array linked list manager: request stage, list control, result register.
//
// Doubly linked list of CAPACITY slots with a free-slot list. Each request
// transfer on s_req (append, remove, read) yields exactly one result transfer
// on m_resp, in order, carrying status, the slot touched, the read slot's data
// and links, and the list head, tail and count after the request.
// Both channels are valid/ready. An accepted request launches the slot store
// read at that edge; the request stage then finishes the request with short
// logic into the result register.
// Throughput: one request per cycle while m_ready stays high, including
// back-to-back removes and appends; the last write of each memory is
// forwarded to the following request, and the free list prefetches the link
// of its second entry so consecutive pops never wait on a memory read.
// When the receiver stalls, the result register holds, the request stage holds
// one more request, and s_ready drops once both are full.
// Reset (aresetn low, synchronous) empties the list and makes every slot free;
// no clearing pass runs. Never-used slots are tracked by a fill counter, so
// the block accepts requests as soon as reset is released.
module array_linked_list_manager_core
    import allm_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  allm_req_t  s_req,
    output logic       m_valid,
    input  logic       m_ready,
    output allm_resp_t m_resp
);

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int PTR_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;
    localparam int STORE_W = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

    // Request stage
    logic              stg_valid_reg;
    logic [REQ_W-1:0]  stg_type_reg;
    logic [SLOT_W-1:0] stg_slot_reg;
    logic [ADDR_W-1:0] stg_addr_reg;
    logic [STORE_W-1:0] stg_word_reg;

    // List state
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0]  count_reg, count_next;

    // Result register
    logic       m_valid_reg;
    allm_resp_t m_resp_reg;
    allm_resp_t resp;

    logic              accept, fire, live;
    logic [ADDR_W-1:0] s_addr;

    allm_free_cmd_t    free_cmd;
    logic [ADDR_W-1:0] free_top;
    logic              free_full;
    logic [PTR_W-1:0]  fresh_count;

    allm_store_wr_t     wr;
    logic [ADDR_W-1:0]  next_waddr, next_wdata, prev_waddr, prev_wdata;
    logic [ADDR_W-1:0]  data_waddr, use_waddr;
    logic [ADDR_W-1:0]  rd_next, rd_prev;
    logic [STORE_W-1:0] rd_data;
    logic               rd_use;

    // Advance the stage when the result register is free or being drained.
    assign fire    = stg_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stg_valid_reg || fire;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_resp  = m_resp_reg;

    // Slots beyond the capacity are never live; point the read at slot zero.
    assign s_addr = (CMP_W'(s_req.slot_index) < CMP_W'(CAPACITY)) ?
                    ADDR_W'(s_req.slot_index) : '0;

    allm_free_list #(
        .CAPACITY (CAPACITY)
    ) u_free_list (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (free_cmd),
        .push_slot   (stg_addr_reg),
        .top_slot    (free_top),
        .full        (free_full),
        .fresh_count (fresh_count)
    );

    allm_slot_store #(
        .CAPACITY (CAPACITY),
        .STORE_W  (STORE_W)
    ) u_slot_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (accept),
        .rd_addr    (s_addr),
        .wr         (wr),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .data_waddr (data_waddr),
        .data_wdata (stg_word_reg),
        .use_waddr  (use_waddr),
        .rd_next    (rd_next),
        .rd_prev    (rd_prev),
        .rd_data    (rd_data),
        .rd_use     (rd_use)
    );

    // A slot is live only if it was ever handed out and is still marked in use.
    assign live = (CMP_W'(stg_slot_reg) < CMP_W'(fresh_count)) && rd_use;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        free_cmd   = '0;
        wr         = '0;
        next_waddr = tail_reg;
        next_wdata = free_top;
        prev_waddr = free_top;
        prev_wdata = tail_reg;
        data_waddr = free_top;
        use_waddr  = free_top;
        resp       = '0;

        case (stg_type_reg)
            REQ_APPEND: begin
                if (free_full) begin
                    resp.status = STATUS_FULL;
                end else begin
                    resp.slot    = SLOT_W'(free_top);
                    free_cmd.pop = 1'b1;
                    wr.data_we   = 1'b1;
                    wr.use_we    = 1'b1;
                    wr.use_val   = 1'b1;
                    wr.prev_we   = 1'b1;
                    // Link after the tail, or start the list on this slot.
                    if (count_reg != '0) begin
                        wr.next_we = 1'b1;
                    end else begin
                        head_next = free_top;
                    end
                    tail_next  = free_top;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_REMOVE: begin
                resp.slot = stg_slot_reg;
                if (!live) begin
                    resp.status = STATUS_NOT_LIVE;
                end else begin
                    // Head has no valid back link, tail no valid forward link.
                    if (stg_addr_reg == head_reg) begin
                        head_next = rd_next;
                    end else begin
                        wr.next_we = 1'b1;
                        next_waddr = rd_prev;
                        next_wdata = rd_next;
                    end
                    if (stg_addr_reg == tail_reg) begin
                        tail_next = rd_prev;
                    end else begin
                        wr.prev_we = 1'b1;
                        prev_waddr = rd_next;
                        prev_wdata = rd_prev;
                    end
                    wr.use_we     = 1'b1;
                    wr.use_val    = 1'b0;
                    use_waddr     = stg_addr_reg;
                    free_cmd.push = 1'b1;
                    count_next    = count_reg - 1'b1;
                end
            end
            REQ_READ: begin
                resp.slot = stg_slot_reg;
                if (!live) begin
                    resp.status = STATUS_NOT_LIVE;
                end else begin
                    resp.data_out = WORD_W'(rd_data);
                    if (stg_addr_reg != head_reg) begin
                        resp.has_prev  = 1'b1;
                        resp.prev_slot = SLOT_W'(rd_prev);
                    end
                    if (stg_addr_reg != tail_reg) begin
                        resp.has_next  = 1'b1;
                        resp.next_slot = SLOT_W'(rd_next);
                    end
                end
            end
            default: begin
            end
        endcase

        resp.list_empty = (count_next == '0);
        resp.head_slot  = (count_next == '0) ? '0 : SLOT_W'(head_next);
        resp.tail_slot  = (count_next == '0) ? '0 : SLOT_W'(tail_next);
        resp.count      = COUNT_W'(count_next);

        // Drop every side effect unless the request actually completes.
        if (!fire) begin
            free_cmd = '0;
            wr       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end else begin
            if (accept) begin
                stg_valid_reg <= 1'b1;
            end else if (fire) begin
                stg_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payload registers; they need no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_type_reg <= s_req.req_type;
            stg_slot_reg <= s_req.slot_index;
            stg_addr_reg <= s_addr;
            stg_word_reg <= s_req.data_word[STORE_W-1:0];
        end
        if (fire) begin
            m_resp_reg <= resp;
        end
    end

endmodule
